/* hdl/rrps_pkg.sv */
// Shared types, constants and helpers for the round-robin process scheduler.
package rrps_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int SLEEP_BITS = 16;
   localparam int IDX_W      = $clog2(NUM_SLOTS);

   // Fixed field widths of the request and response items
   localparam int OP_W     = 3;
   localparam int TICKS_W  = 16;
   localparam int SLOT_W   = 3;
   localparam int STATUS_W = 2;
   localparam int LIMIT_W  = 8;

   localparam logic [LIMIT_W-1:0] SLICE_LIMIT_RESET = LIMIT_W'(16);
   localparam longint unsigned SLEEP_MAX = (64'd1 << SLEEP_BITS) - 64'd1;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 3'd0,
      OP_SLEEP = 3'd1,
      OP_EXIT  = 3'd2,
      OP_BLOCK = 3'd3,
      OP_WAKE  = 3'd4,
      OP_FORK  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_DEAD     = 2'd0,
      ST_RUNNABLE = 2'd1,
      ST_RUNNING  = 2'd2,
      ST_BLOCKED  = 2'd3
   } slot_state_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 2'd0,
      STAT_NO_FREE     = 2'd1,
      STAT_NOT_BLOCKED = 2'd2
   } status_type;

   // Decoded request, broadcast to every cell
   typedef struct packed {
      logic                  fire;
      logic                  do_tick;
      logic                  op_sleep;
      logic                  op_exit;
      logic                  op_block;
      logic                  op_wake;
      logic                  op_fork;
      logic [IDX_W-1:0]      cur;
      logic [IDX_W-1:0]      target;
      logic [SLEEP_BITS-1:0] ticks;
   } cmd_type;

   // Scheduling decision, broadcast back to every cell
   typedef struct packed {
      logic             advance;
      logic [IDX_W-1:0] pick;
   } sched_type;

   // Ripple chain between neighboring cells: first dead slot, and the
   // rotating search split into slots above and below the running one
   typedef struct packed {
      logic             fork_taken;
      logic [IDX_W-1:0] fork_idx;
      logic             hi_taken;
      logic [IDX_W-1:0] hi_idx;
      logic             lo_taken;
      logic [IDX_W-1:0] lo_idx;
   } chain_type;

   typedef struct packed {
      logic cur_run;
      logic cur_rdy;
      logic wake_hit;
      logic running;
   } cell_stat_type;

   function automatic logic [SLEEP_BITS-1:0] sat_ticks(input logic [TICKS_W-1:0] ticks);
      logic [63:0] wide;
      wide = 64'(ticks);
      if (wide > SLEEP_MAX) begin
         return {SLEEP_BITS{1'b1}};
      end
      return SLEEP_BITS'(wide);
   endfunction

endpackage

/* hdl/rrps_req_if.sv */
// Request channel: one scheduler operation per request.
interface rrps_req_if;
   logic                         valid;
   logic                         ready;
   logic [rrps_pkg::OP_W-1:0]    opcode;
   logic [rrps_pkg::TICKS_W-1:0] sleep_ticks;
   logic [rrps_pkg::SLOT_W-1:0]  target_slot;

   modport source (output valid, opcode, sleep_ticks, target_slot, input ready);
   modport sink   (input valid, opcode, sleep_ticks, target_slot, output ready);
endinterface

/* hdl/rrps_rsp_if.sv */
// Response channel: outcome of one scheduler operation.
interface rrps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rrps_pkg::SLOT_W-1:0]   running_slot;
   logic                          switched;
   logic [rrps_pkg::SLOT_W-1:0]   new_slot;
   logic [rrps_pkg::STATUS_W-1:0] status;

   modport source (output valid, running_slot, switched, new_slot, status, input ready);
   modport sink   (input valid, running_slot, switched, new_slot, status, output ready);
endinterface

/* hdl/rrps_csr_if.sv */
// Control register write channel: slice limit.
interface rrps_csr_if;
   logic                         valid;
   logic                         ready;
   logic [rrps_pkg::LIMIT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* hdl/rrps_cell.sv */
// One process slot: state, sleep countdown, blocked mark and chain logic.
module rrps_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rrps_pkg::IDX_W-1:0]   slot_id,
   input  rrps_pkg::cmd_type            cmd,
   input  rrps_pkg::sched_type          sched,
   input  rrps_pkg::chain_type          chain_in,
   output rrps_pkg::chain_type          chain_out,
   output rrps_pkg::cell_stat_type      stat
);

   rrps_pkg::slot_state_type            state_ff, state_in;
   logic [rrps_pkg::SLEEP_BITS-1:0]     sleep_ff, sleep_in;
   logic                                forever_ff, forever_in;

   rrps_pkg::slot_state_type            st1, st2;
   logic [rrps_pkg::SLEEP_BITS-1:0]     sl1, sl2;
   logic                                bf1;
   logic                                is_cur;
   logic                                dead_now;
   logic                                fork_gnt;
   logic                                wake_hit;
   logic                                cand;
   logic                                cand_hi;
   logic                                cand_lo;

   always_comb begin
      is_cur   = (slot_id == cmd.cur);
      dead_now = (state_ff == rrps_pkg::ST_DEAD);
      fork_gnt = cmd.op_fork && dead_now && !chain_in.fork_taken;
      wake_hit = cmd.op_wake && (slot_id == cmd.target) &&
                 (state_ff == rrps_pkg::ST_BLOCKED);

      // operation applied before the tick
      st1 = state_ff;
      sl1 = sleep_ff;
      bf1 = forever_ff;
      if (is_cur && cmd.op_sleep) begin
         st1 = rrps_pkg::ST_BLOCKED;
         bf1 = 1'b0;
         sl1 = cmd.ticks;
      end else if (is_cur && cmd.op_exit) begin
         st1 = rrps_pkg::ST_DEAD;
      end else if (is_cur && cmd.op_block) begin
         st1 = rrps_pkg::ST_BLOCKED;
         bf1 = 1'b1;
      end else if (wake_hit || fork_gnt) begin
         st1 = rrps_pkg::ST_RUNNABLE;
         sl1 = '0;
         bf1 = 1'b0;
      end

      // timed countdown, running slot excluded
      st2 = st1;
      sl2 = sl1;
      if (cmd.do_tick && !is_cur && st1 == rrps_pkg::ST_BLOCKED && !bf1) begin
         if (sl1 <= rrps_pkg::SLEEP_BITS'(1)) begin
            sl2 = '0;
            st2 = rrps_pkg::ST_RUNNABLE;
         end else begin
            sl2 = sl1 - rrps_pkg::SLEEP_BITS'(1);
         end
      end

      cand    = (st2 == rrps_pkg::ST_RUNNABLE) && (slot_id != '0) && !is_cur;
      cand_hi = cand && (slot_id > cmd.cur);
      cand_lo = cand && (slot_id < cmd.cur);

      chain_out.fork_taken = chain_in.fork_taken || dead_now;
      chain_out.fork_idx   = fork_gnt ? slot_id : chain_in.fork_idx;
      chain_out.hi_taken   = chain_in.hi_taken || cand_hi;
      chain_out.hi_idx     = (cand_hi && !chain_in.hi_taken) ? slot_id : chain_in.hi_idx;
      chain_out.lo_taken   = chain_in.lo_taken || cand_lo;
      chain_out.lo_idx     = (cand_lo && !chain_in.lo_taken) ? slot_id : chain_in.lo_idx;

      stat.cur_run  = is_cur && (st2 == rrps_pkg::ST_RUNNING);
      stat.cur_rdy  = is_cur && (st2 == rrps_pkg::ST_RUNNING ||
                                 st2 == rrps_pkg::ST_RUNNABLE);
      stat.wake_hit = wake_hit;
      stat.running  = (state_ff == rrps_pkg::ST_RUNNING);

      state_in = st2;
      if (sched.advance) begin
         if (slot_id == sched.pick) begin
            state_in = rrps_pkg::ST_RUNNING;
         end else if (is_cur && st2 == rrps_pkg::ST_RUNNING) begin
            state_in = rrps_pkg::ST_RUNNABLE;
         end
      end
      sleep_in   = sl2;
      forever_in = bf1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= (slot_id == '0) ? rrps_pkg::ST_RUNNING : rrps_pkg::ST_DEAD;
         sleep_ff   <= '0;
         forever_ff <= 1'b0;
      end else if (cmd.fire) begin
         state_ff   <= state_in;
         sleep_ff   <= sleep_in;
         forever_ff <= forever_in;
      end
   end

endmodule

/* hdl/round_robin_process_scheduler.sv */
// Top level of the round-robin process scheduler: request decode, cell row, response register.
//
// Usage:
//   req_bus carries one operation per request (tick, sleep, exit, block,
//   wake, fork). rsp_bus returns exactly one response per request: the
//   slot running afterwards, whether a new scheduling decision was made,
//   the slot a fork allocated and a status code. csr_bus writes the slice
//   limit; it is always ready and should be written only while idle.
//   A request accepted at one edge has its response valid after that
//   edge. Throughput: one request per cycle while the output register
//   is free or drains; the whole operation, including the rotating search,
//   is decided combinationally by the ripple chain through the slot cells.
//   A response that the receiver stalls stays in the output register; a
//   new request is taken in the same cycle the held response leaves.
//   Reset: slot 0 running with slice count one, all other slots dead,
//   slice limit 16, no response pending.
module round_robin_process_scheduler (
   input  logic        clock,
   input  logic        reset,
   rrps_req_if.sink    req_bus,
   rrps_rsp_if.source  rsp_bus,
   rrps_csr_if.sink    csr_bus
);

   logic [rrps_pkg::LIMIT_W-1:0]  limit_ff;
   logic [rrps_pkg::LIMIT_W-1:0]  used_ff, used_in;
   logic [rrps_pkg::IDX_W-1:0]    running_ff, running_in;
   logic                          rsp_valid_ff;
   logic [rrps_pkg::SLOT_W-1:0]   rsp_running_ff;
   logic                          rsp_switched_ff;
   logic [rrps_pkg::SLOT_W-1:0]   rsp_new_ff;
   logic [rrps_pkg::STATUS_W-1:0] rsp_status_ff;

   rrps_pkg::cmd_type             cmd;
   rrps_pkg::sched_type           sched;
   rrps_pkg::chain_type           chain [rrps_pkg::NUM_SLOTS+1];
   rrps_pkg::cell_stat_type       stat  [rrps_pkg::NUM_SLOTS];
   logic [rrps_pkg::NUM_SLOTS-1:0] run_mask;
   logic                          any_cur_run;
   logic                          any_cur_rdy;
   logic                          any_wake;
   logic                          keep;
   logic                          fire;
   rrps_pkg::status_type          status;

   assign fire          = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cmd          = '0;
      cmd.fire     = fire;
      cmd.cur      = running_ff;
      cmd.target   = rrps_pkg::IDX_W'(req_bus.target_slot);
      cmd.ticks    = rrps_pkg::sat_ticks(req_bus.sleep_ticks);
      unique case (rrps_pkg::op_type'(req_bus.opcode))
         rrps_pkg::OP_TICK: begin
            cmd.do_tick = fire;
         end
         rrps_pkg::OP_SLEEP: begin
            cmd.op_sleep = fire && (req_bus.sleep_ticks != '0);
            cmd.do_tick  = fire && (req_bus.sleep_ticks != '0);
         end
         rrps_pkg::OP_EXIT: begin
            cmd.op_exit = fire;
            cmd.do_tick = fire;
         end
         rrps_pkg::OP_BLOCK: begin
            cmd.op_block = fire;
            cmd.do_tick  = fire;
         end
         rrps_pkg::OP_WAKE: begin
            cmd.op_wake = fire && (32'(req_bus.target_slot) < rrps_pkg::NUM_SLOTS);
         end
         rrps_pkg::OP_FORK: begin
            cmd.op_fork = fire;
         end
         default: begin
         end
      endcase
   end

   assign chain[0] = '0;

   for (genvar g = 0; g < rrps_pkg::NUM_SLOTS; g++) begin : g_cell
      rrps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .slot_id   (rrps_pkg::IDX_W'(g)),
         .cmd       (cmd),
         .sched     (sched),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1]),
         .stat      (stat[g])
      );
   end

   always_comb begin
      any_cur_run = 1'b0;
      any_cur_rdy = 1'b0;
      any_wake    = 1'b0;
      for (int i = 0; i < rrps_pkg::NUM_SLOTS; i++) begin
         any_cur_run = any_cur_run | stat[i].cur_run;
         any_cur_rdy = any_cur_rdy | stat[i].cur_rdy;
         any_wake    = any_wake | stat[i].wake_hit;
         run_mask[i] = stat[i].running;
      end
   end

   always_comb begin
      keep          = any_cur_run && (used_ff != limit_ff);
      sched.advance = cmd.do_tick && !keep;
      if (chain[rrps_pkg::NUM_SLOTS].hi_taken) begin
         sched.pick = chain[rrps_pkg::NUM_SLOTS].hi_idx;
      end else if (chain[rrps_pkg::NUM_SLOTS].lo_taken) begin
         sched.pick = chain[rrps_pkg::NUM_SLOTS].lo_idx;
      end else if (any_cur_rdy) begin
         sched.pick = running_ff;
      end else begin
         sched.pick = '0;  // idle slot
      end

      running_in = sched.advance ? sched.pick : running_ff;
      used_in    = used_ff;
      if (cmd.do_tick) begin
         used_in = keep ? used_ff + rrps_pkg::LIMIT_W'(1) : rrps_pkg::LIMIT_W'(1);
      end

      status = rrps_pkg::STAT_OK;
      if (cmd.op_fork && !chain[rrps_pkg::NUM_SLOTS].fork_taken) begin
         status = rrps_pkg::STAT_NO_FREE;
      end else if (fire && rrps_pkg::op_type'(req_bus.opcode) == rrps_pkg::OP_WAKE &&
                   !any_wake) begin
         status = rrps_pkg::STAT_NOT_BLOCKED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= rrps_pkg::SLICE_LIMIT_RESET;
         used_ff      <= rrps_pkg::LIMIT_W'(1);
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            limit_ff <= csr_bus.data;
         end
         if (fire) begin
            used_ff      <= used_in;
            running_ff   <= running_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_running_ff  <= rrps_pkg::SLOT_W'(running_in);
         rsp_switched_ff <= sched.advance;
         rsp_new_ff      <= (cmd.op_fork && chain[rrps_pkg::NUM_SLOTS].fork_taken) ?
                            rrps_pkg::SLOT_W'(chain[rrps_pkg::NUM_SLOTS].fork_idx) : '0;
         rsp_status_ff   <= status;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.running_slot = rsp_running_ff;
   assign rsp_bus.switched     = rsp_switched_ff;
   assign rsp_bus.new_slot     = rsp_new_ff;
   assign rsp_bus.status       = rsp_status_ff;

`ifndef ASSERT_OFF
   // exactly one slot is running, and it is the one the index points at
   a_one_running: assert property (@(posedge clock) disable iff (reset)
      $onehot(run_mask) && run_mask[running_ff])
      else $error("running slot and slot states disagree");

   // a switch never comes with a fork result or an error status
   a_switch_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.switched |->
         rsp_bus.status == rrps_pkg::STAT_OK && rsp_bus.new_slot == '0)
      else $error("switch reported with fork or error fields");

   // every accepted request yields a pending response
   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_bus.valid)
      else $error("accepted request produced no response");

   // the slice count restarts at one after every decision
   a_slice_restart: assert property (@(posedge clock) disable iff (reset)
      fire && sched.advance |=> used_ff == rrps_pkg::LIMIT_W'(1))
      else $error("slice count not restarted on switch");
`endif

endmodule

/* dv/tb_round_robin_process_scheduler.sv */
// Testbench for the round-robin process scheduler: scoreboard against an in-bench scheduler model.
module tb_round_robin_process_scheduler;
   import rrps_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
   localparam int QUIET_LIMIT = 1000;

   typedef struct packed {
      logic [SLOT_W-1:0] running_slot;
      logic              switched;
      logic [SLOT_W-1:0] new_slot;
      status_type        status;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset;

   rrps_req_if req_bus ();
   rrps_rsp_if rsp_bus ();
   rrps_csr_if csr_bus ();

   round_robin_process_scheduler u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   // scheduler model state
   slot_state_type        slot_st      [NUM_SLOTS];
   logic [SLEEP_BITS-1:0] sleep_cnt    [NUM_SLOTS];
   logic                  forever_mark [NUM_SLOTS];
   logic [IDX_W-1:0]      run_slot;
   logic [LIMIT_W-1:0]    slice_cnt;
   logic [LIMIT_W-1:0]    slice_limit;

   sched_result_type pending_results[$];
   int            errors = 0;
   int            quiet_cycles = 0;
   int            burst_left = 0;
   bit            use_gaps = 1'b0;
   int            rsp_stall_mode = 0;
   int unsigned   stall_phase = 0;

   // One tick: count down sleepers, then either charge the slice or reschedule.
   function automatic logic advance_slice();
      int unsigned cur, idx, pick, s, k;
      logic found;
      cur   = run_slot;
      found = 1'b0;
      for (s = 0; s < NUM_SLOTS; s++) begin
         if (s != cur && slot_st[s] == ST_BLOCKED && !forever_mark[s]) begin
            if (sleep_cnt[s] <= 1) begin
               sleep_cnt[s] = '0;
               slot_st[s]   = ST_RUNNABLE;
            end else begin
               sleep_cnt[s] = sleep_cnt[s] - 1'b1;
            end
         end
      end
      if (slot_st[cur] == ST_RUNNING && slice_cnt != slice_limit) begin
         slice_cnt = slice_cnt + 1'b1;
         return 1'b0;
      end
      if (slot_st[cur] == ST_RUNNING) begin
         slot_st[cur] = ST_RUNNABLE;
         slice_cnt    = '0;
      end
      pick = cur;
      for (k = 1; k < NUM_SLOTS; k++) begin
         idx = (cur + k) % NUM_SLOTS;
         if (!found && idx != 0 && slot_st[idx] == ST_RUNNABLE) begin
            pick  = idx;
            found = 1'b1;
         end
      end
      // idle slot takes over whatever state it was left in
      if (!found && slot_st[pick] != ST_RUNNABLE) pick = 0;
      run_slot      = IDX_W'(pick);
      slot_st[pick] = ST_RUNNING;
      slice_cnt     = LIMIT_W'(1);
      return 1'b1;
   endfunction

   function automatic sched_result_type run_scheduler_op(input logic [OP_W-1:0] opc,
                                                         input logic [TICKS_W-1:0] ticks,
                                                         input logic [SLOT_W-1:0] tgt);
      sched_result_type r;
      int unsigned cur, s;
      logic hit;
      cur        = run_slot;
      hit        = 1'b0;
      r.switched = 1'b0;
      r.new_slot = '0;
      r.status   = STAT_OK;
      case (opc)
         OP_TICK: r.switched = advance_slice();
         OP_SLEEP: begin
            if (ticks != 0) begin
               slot_st[cur]      = ST_BLOCKED;
               forever_mark[cur] = 1'b0;
               sleep_cnt[cur]    = ticks;
               r.switched        = advance_slice();
            end
         end
         OP_EXIT: begin
            slot_st[cur] = ST_DEAD;
            r.switched   = advance_slice();
         end
         OP_BLOCK: begin
            slot_st[cur]      = ST_BLOCKED;
            forever_mark[cur] = 1'b1;
            r.switched        = advance_slice();
         end
         OP_WAKE: begin
            if (slot_st[tgt] == ST_BLOCKED) begin
               slot_st[tgt]      = ST_RUNNABLE;
               sleep_cnt[tgt]    = '0;
               forever_mark[tgt] = 1'b0;
            end else begin
               r.status = STAT_NOT_BLOCKED;
            end
         end
         OP_FORK: begin
            for (s = 0; s < NUM_SLOTS; s++) begin
               if (!hit && slot_st[s] == ST_DEAD) begin
                  hit             = 1'b1;
                  slot_st[s]      = ST_RUNNABLE;
                  sleep_cnt[s]    = '0;
                  forever_mark[s] = 1'b0;
                  r.new_slot      = SLOT_W'(s);
               end
            end
            if (!hit) r.status = STAT_NO_FREE;
         end
         default: ;
      endcase
      r.running_slot = SLOT_W'(run_slot);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   // Scoreboard and idle watchdog
   always @(posedge clock) begin
      sched_result_type want;
      int s;
      if (reset) begin
         for (s = 0; s < NUM_SLOTS; s++) begin
            slot_st[s]      = ST_DEAD;
            sleep_cnt[s]    = '0;
            forever_mark[s] = 1'b0;
         end
         slot_st[0]  = ST_RUNNING;
         run_slot    = '0;
         slice_cnt   = LIMIT_W'(1);
         slice_limit = SLICE_LIMIT_RESET;
         pending_results.delete();
         quiet_cycles = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               errors++;
               $display("%0t: response with no request outstanding, slot %0d", $time,
                        rsp_bus.running_slot);
            end else begin
               want = pending_results.pop_front();
               check_field("running_slot", want.running_slot, rsp_bus.running_slot);
               check_field("switched", want.switched, rsp_bus.switched);
               check_field("new_slot", want.new_slot, rsp_bus.new_slot);
               check_field("status", want.status, rsp_bus.status);
            end
         end
         if (csr_bus.valid && csr_bus.ready) slice_limit = csr_bus.data;
         if (req_bus.valid && req_bus.ready)
            pending_results.push_back(run_scheduler_op(req_bus.opcode, req_bus.sleep_ticks,
                                                       req_bus.target_slot));
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Response back-pressure
   always @(negedge clock) begin
      stall_phase++;
      case (rsp_stall_mode)
         1: rsp_bus.ready = ($urandom_range(0, 99) >= 30);
         2: rsp_bus.ready = ((stall_phase % 9) < 6);
         default: rsp_bus.ready = 1'b1;
      endcase
   end

   task automatic send_op(input logic [OP_W-1:0] opc, input logic [TICKS_W-1:0] ticks,
                          input logic [SLOT_W-1:0] tgt, input bit aim_blocked = 1'b0);
      int gap, s;
      int unsigned blocked_slots[$];
      if (use_gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = $urandom_range(1, 6);
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      // model state is settled here, so pick a slot that is really blocked
      if (aim_blocked) begin
         for (s = 0; s < NUM_SLOTS; s++)
            if (slot_st[s] == ST_BLOCKED) blocked_slots.push_back(s);
         if (blocked_slots.size() != 0)
            tgt = SLOT_W'(blocked_slots[$urandom_range(0, blocked_slots.size() - 1)]);
      end
      req_bus.valid       = 1'b1;
      req_bus.opcode      = opc;
      req_bus.sleep_ticks = ticks;
      req_bus.target_slot = tgt;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_slice_limit(input logic [LIMIT_W-1:0] lim);
      hold_until_drained();
      csr_bus.valid = 1'b1;
      csr_bus.data  = lim;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Reset limit, every opcode, wake/fork error paths, sleep extremes
   task automatic test_basic_ops();
      int n;
      rsp_stall_mode = 0;
      use_gaps       = 1'b0;
      send_op(OP_TICK, '0, '0);
      send_op(OP_SPARE_6, 16'hFFFF, 3'd7);
      send_op(OP_SPARE_7, 16'h5A5A, 3'd5);
      send_op(OP_SLEEP, '0, '0);
      send_op(OP_WAKE, '0, 3'd3);
      for (n = 0; n < NUM_SLOTS; n++) send_op(OP_FORK, '0, '0);
      send_op(OP_SLEEP, 16'hFFFF, '0);
      send_op(OP_SLEEP, 16'd1, '0);
      send_op(OP_BLOCK, '0, '0);
      send_op(OP_EXIT, '0, '0);
      send_op(OP_WAKE, '0, 3'd2);
      send_op(OP_WAKE, '0, 3'd3);
      send_op(OP_WAKE, '0, 3'd0);
      send_op(OP_TICK, '0, 3'd7);
   endtask

   // Long tick runs so the largest limit and the wrap-to-zero limit both preempt
   task automatic test_slice_extremes();
      int n;
      rsp_stall_mode = 1;
      use_gaps       = 1'b1;
      write_slice_limit(8'd255);
      send_op(OP_FORK, '0, '0);
      for (n = 0; n < 270; n++) send_op(OP_TICK, 16'($urandom), 3'($urandom));
      write_slice_limit(8'd0);
      send_op(OP_FORK, '0, '0);
      for (n = 0; n < 270; n++) send_op(OP_TICK, 16'($urandom), 3'($urandom));
      write_slice_limit(8'd1);
      for (n = 0; n < 12; n++) send_op(OP_TICK, '0, '0);
   endtask

   task automatic test_random_phase(input logic [LIMIT_W-1:0] lim, input int count,
                                    input int stall, input bit gaps);
      int n;
      int unsigned roll;
      logic [OP_W-1:0] opc;
      logic [TICKS_W-1:0] ticks;
      logic [SLOT_W-1:0] tgt;
      bit aim;
      write_slice_limit(lim);
      rsp_stall_mode = stall;
      use_gaps       = gaps;
      for (n = 0; n < count; n++) begin
         roll  = $urandom_range(0, 99);
         ticks = 16'($urandom);
         tgt   = 3'($urandom);
         aim   = 1'b0;
         if (roll < 34) opc = OP_TICK;
         else if (roll < 50) opc = OP_FORK;
         else if (roll < 64) begin
            opc = OP_SLEEP;
            case ($urandom_range(0, 9))
               0: ticks = '0;
               1: ticks = 16'hFFFF;
               2: ticks = 16'($urandom);
               default: ticks = 16'($urandom_range(1, 12));
            endcase
         end else if (roll < 71) opc = OP_EXIT;
         else if (roll < 78) opc = OP_BLOCK;
         else if (roll < 96) begin
            opc = OP_WAKE;
            aim = ($urandom_range(0, 3) != 0);
         end else opc = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
         // occasionally let every response come back before the next request
         if ($urandom_range(0, 79) == 0) hold_until_drained();
         send_op(opc, ticks, tgt, aim);
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = '0;
      req_bus.sleep_ticks = '0;
      req_bus.target_slot = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.data        = '0;
      rsp_bus.ready       = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_slice_extremes();
      test_random_phase(8'd3, 60, 0, 1'b0);
      test_random_phase(8'd1, 60, 1, 1'b1);
      test_random_phase(8'd255, 60, 2, 1'b1);
      test_random_phase(8'd0, 60, 1, 1'b0);
      test_random_phase(LIMIT_W'($urandom_range(2, 254)), 80, 2, 1'b0);
      test_random_phase(8'd16, 60, 1, 1'b1);

      hold_until_drained();
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* sim.f */
hdl/rrps_pkg.sv
hdl/rrps_req_if.sv
hdl/rrps_rsp_if.sv
hdl/rrps_csr_if.sv
hdl/rrps_cell.sv
hdl/round_robin_process_scheduler.sv
dv/tb_round_robin_process_scheduler.sv
